// ----- rtl/core/ecgf_pkg.sv -----
// ----------------------------------------------------------------------------
// ecgf_pkg - shared types and constants of the encoder count glitch filter
// Fixed field widths, the decode offset and the jump limit reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package ecgf_pkg;

  // Field widths fixed by the counter word and the result format
  localparam int RAW_W = 32;
  localparam int MAG_W = 24;
  localparam int CNT_W = 26;
  localparam int LIM_W = 25;
  // Sample plus or minus limit plus or minus one
  localparam int DIF_W = 27;

  // Bit of the raw word that subtracts the sign offset
  localparam int SIGN_BIT = 31;

  typedef logic signed [CNT_W-1:0] count_t;
  typedef logic signed [DIF_W-1:0] dif_t;
  typedef logic [LIM_W-1:0]        limit_t;

  localparam count_t SIGN_OFFSET = 26'sd16777216;
  localparam limit_t LIMIT_RESET = 25'd4000;

endpackage : ecgf_pkg

`default_nettype wire

// ----- rtl/core/encoder_count_glitch_filter_top.sv -----
// ----------------------------------------------------------------------------
// encoder_count_glitch_filter_top - quadrature count decode and glitch filter
// Decodes raw counter words into signed, direction-reversed counts and
// replaces outliers against a moving window average by the newest stored
// sample.
//
//   channel  ports                                 handshake
//   in       in_raw_word[31:0]                     in_valid / in_ready
//   out      out_filtered_count[25:0], out_was_rejected  out_valid / out_ready
//   cfg      cfg_wr_data[24:0] (jump_limit)        cfg_wr_en, no wait
//
// One request per cycle sustained while out_ready stays high; a result passes
// the decode stage, threshold stage and output register in that order.
// The feedback loop is the running-sum compare and update in the window.
// Reset clears the fill count, running sum and stage valids; jump_limit
// returns to 4000. A stalled output holds each full stage whose successor
// is full, and in_ready drops only when all stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_count_glitch_filter_top
  import ecgf_pkg::*;
#(
  parameter int WINDOW = 10
)
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_wr_en,
  input  wire  [LIM_W-1:0] cfg_wr_data,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [RAW_W-1:0] in_raw_word,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [CNT_W-1:0] out_filtered_count,
  output logic             out_was_rejected
);

  localparam int THR_W = 28 + $clog2(WINDOW);

  limit_t jump_limit_r, jump_limit_nxt;

  logic             p_valid;
  logic             o_load;
  logic             take;
  count_t           p_sample;
  logic [THR_W-1:0] p_lo_pos, p_lo_neg, p_hi_pos, p_hi_neg;
  count_t           res_count;
  logic             res_rejected;

  logic   out_valid_r, out_valid_nxt;
  count_t out_count_r;
  logic   out_rej_r;

  // Write the limit register
  always_comb begin
    jump_limit_nxt = jump_limit_r;
    if (cfg_wr_en) begin
      jump_limit_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_limit_r <= LIMIT_RESET;
    end else begin
      jump_limit_r <= jump_limit_nxt;
    end
  end

  ecgf_prep #(
    .WINDOW (WINDOW),
    .THR_W  (THR_W)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_word   (in_raw_word),
    .limit     (jump_limit_r),
    .dn_valid  (p_valid),
    .dn_ready  (o_load),
    .dn_sample (p_sample),
    .dn_lo_pos (p_lo_pos),
    .dn_lo_neg (p_lo_neg),
    .dn_hi_pos (p_hi_pos),
    .dn_hi_neg (p_hi_neg)
  );

  // Output register frees when empty or drained this cycle
  assign o_load = !out_valid_r || out_ready;
  assign take   = p_valid && o_load;

  ecgf_window #(
    .WINDOW (WINDOW),
    .THR_W  (THR_W)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .sample       (p_sample),
    .lo_pos       (p_lo_pos),
    .lo_neg       (p_lo_neg),
    .hi_pos       (p_hi_pos),
    .hi_neg       (p_hi_neg),
    .res_count    (res_count),
    .res_rejected (res_rejected)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (o_load) begin
      out_valid_nxt = p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result as the request leaves the window stage
  always_ff @(posedge clk) begin
    if (take) begin
      out_count_r <= res_count;
      out_rej_r   <= res_rejected;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_count = out_count_r;
  assign out_was_rejected   = out_rej_r;

endmodule : encoder_count_glitch_filter_top

`default_nettype wire

// ----- rtl/core/ecgf_cell.sv -----
// ----------------------------------------------------------------------------
// ecgf_cell - one entry of the sample window
// Holds one stored sample and takes its neighbor's value on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ecgf_cell
  import ecgf_pkg::*;
(
  input  wire    clk,
  input  wire    shift_en,
  input  count_t shift_in,
  output count_t value
);

  count_t value_r;
  count_t value_nxt;

  // Take the neighbor's sample on a shift, hold otherwise
  always_comb begin
    value_nxt = value_r;
    if (shift_en) begin
      value_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule : ecgf_cell

`default_nettype wire

// ----- rtl/core/ecgf_prep.sv -----
// ----------------------------------------------------------------------------
// ecgf_prep - decode and threshold stages
// Decodes the raw counter word into a signed, direction-reversed sample and
// scales the acceptance bounds by the window length, so the decision stage
// compares the running sum directly and never divides.
// ----------------------------------------------------------------------------
`default_nettype none

module ecgf_prep
  import ecgf_pkg::*;
#(
  parameter int WINDOW = 10,
  parameter int THR_W  = 28 + $clog2(WINDOW)
)
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              up_valid,
  output logic             up_ready,
  input  wire  [RAW_W-1:0] up_word,
  input  limit_t           limit,
  output logic             dn_valid,
  input  wire              dn_ready,
  output count_t           dn_sample,
  output logic [THR_W-1:0] dn_lo_pos,
  output logic [THR_W-1:0] dn_lo_neg,
  output logic [THR_W-1:0] dn_hi_pos,
  output logic [THR_W-1:0] dn_hi_neg
);

  localparam logic signed [THR_W-1:0] WIN_S = THR_W'(WINDOW);
  localparam dif_t ONE_D = DIF_W'(1);

  logic en_a;
  logic en_b;

  // Stage A: decoded sample and unscaled bounds
  logic   a_valid_r, a_valid_nxt;
  count_t a_sample_r;
  dif_t   a_lo_r, a_lo_m1_r, a_hi_r, a_hi_p1_r;

  // Stage B: bounds scaled by the window length
  logic                     b_valid_r, b_valid_nxt;
  count_t                   b_sample_r;
  logic signed [THR_W-1:0]  b_lo_pos_r, b_lo_neg_r, b_hi_pos_r, b_hi_neg_r;

  count_t mag_x;
  count_t base;
  count_t sample;
  dif_t   sample_d;
  dif_t   limit_d;
  dif_t   lo_d, hi_d;

  logic signed [THR_W-1:0] lo_x, lo_m1_x, hi_x, hi_p1_x;

  // Advance each stage when it is empty or its successor moves
  assign en_b     = !b_valid_r || dn_ready;
  assign en_a     = !a_valid_r || en_b;
  assign up_ready = en_a;

  // Decode: magnitude, minus 2^24 when flagged, then reverse direction
  always_comb begin
    mag_x    = count_t'({{(CNT_W-MAG_W){1'b0}}, up_word[MAG_W-1:0]});
    base     = up_word[SIGN_BIT] ? SIGN_OFFSET : '0;
    sample   = base - mag_x;
    sample_d = dif_t'({{(DIF_W-CNT_W){sample[CNT_W-1]}}, sample});
    limit_d  = dif_t'({{(DIF_W-LIM_W){1'b0}}, limit});
    lo_d     = sample_d - limit_d;
    hi_d     = sample_d + limit_d;
  end

  // Sign-extend the stage A bounds to threshold width
  always_comb begin
    lo_x    = {{(THR_W-DIF_W){a_lo_r[DIF_W-1]}},    a_lo_r};
    lo_m1_x = {{(THR_W-DIF_W){a_lo_m1_r[DIF_W-1]}}, a_lo_m1_r};
    hi_x    = {{(THR_W-DIF_W){a_hi_r[DIF_W-1]}},    a_hi_r};
    hi_p1_x = {{(THR_W-DIF_W){a_hi_p1_r[DIF_W-1]}}, a_hi_p1_r};
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    b_valid_nxt = b_valid_r;
    if (en_a) begin
      a_valid_nxt = up_valid;
    end
    if (en_b) begin
      b_valid_nxt = a_valid_r;
    end
  end

  // Hold control state in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // Load stage A payload
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_sample_r <= sample;
      a_lo_r     <= lo_d;
      a_lo_m1_r  <= lo_d - ONE_D;
      a_hi_r     <= hi_d;
      a_hi_p1_r  <= hi_d + ONE_D;
    end
  end

  // Load stage B payload: scale by the window length
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_sample_r <= a_sample_r;
      b_lo_pos_r <= lo_x * WIN_S;
      b_lo_neg_r <= lo_m1_x * WIN_S;
      b_hi_pos_r <= hi_p1_x * WIN_S;
      b_hi_neg_r <= hi_x * WIN_S;
    end
  end

  assign dn_valid  = b_valid_r;
  assign dn_sample = b_sample_r;
  assign dn_lo_pos = b_lo_pos_r;
  assign dn_lo_neg = b_lo_neg_r;
  assign dn_hi_pos = b_hi_pos_r;
  assign dn_hi_neg = b_hi_neg_r;

endmodule : ecgf_prep

`default_nettype wire

// ----- rtl/core/ecgf_window.sv -----
// ----------------------------------------------------------------------------
// ecgf_window - sample window, running sum and reject decision
// A row of cells holds the last accepted samples, oldest at entry 0. The
// running sum is compared against prescaled bounds, which is exact for the
// average truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ecgf_window
  import ecgf_pkg::*;
#(
  parameter int WINDOW = 10,
  parameter int THR_W  = 28 + $clog2(WINDOW)
)
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              take,
  input  count_t           sample,
  input  wire  [THR_W-1:0] lo_pos,
  input  wire  [THR_W-1:0] lo_neg,
  input  wire  [THR_W-1:0] hi_pos,
  input  wire  [THR_W-1:0] hi_neg,
  output count_t           res_count,
  output logic             res_rejected
);

  localparam int SUM_W  = 26 + $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);

  count_t cell_q [WINDOW];

  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  logic                    full;
  logic                    shift;
  logic                    rej_cond;
  logic                    rej;
  logic signed [THR_W-1:0] sum_x;
  logic signed [SUM_W-1:0] add_x;
  logic signed [SUM_W-1:0] drop_x;

  assign full = (fill_r == FILL_W'(WINDOW));

  // Compare the sum against the bounds; the sign picks floor or ceiling form
  always_comb begin
    sum_x = {{(THR_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
    if (sum_r[SUM_W-1]) begin
      rej_cond = (sum_x <= $signed(lo_neg)) || (sum_x > $signed(hi_neg));
    end else begin
      rej_cond = (sum_x < $signed(lo_pos)) || (sum_x >= $signed(hi_pos));
    end
    rej   = full && rej_cond;
    shift = take && !rej;
  end

  // Row of cells: shift toward entry 0, newest enters at the top
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    count_t nb;
    if (i == WINDOW - 1) begin : g_top
      assign nb = sample;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    ecgf_cell u_cell (
      .clk      (clk),
      .shift_en (shift),
      .shift_in (nb),
      .value    (cell_q[i])
    );
  end

  // Advance running sum and fill count; drop the oldest once full
  always_comb begin
    add_x    = {{(SUM_W-CNT_W){sample[CNT_W-1]}}, sample};
    drop_x   = full ? {{(SUM_W-CNT_W){cell_q[0][CNT_W-1]}}, cell_q[0]} : '0;
    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    if (shift) begin
      sum_nxt = sum_r + add_x - drop_x;
      if (!full) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Replace a rejected sample by the newest stored one
  assign res_count    = rej ? cell_q[WINDOW-1] : sample;
  assign res_rejected = rej;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill count beyond window length");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !full |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("fill count did not advance during fill");

  a_rej_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
    take && rej |=> sum_r == $past(sum_r))
    else $error("running sum changed on a rejected request");

  a_rej_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    take && !full |-> !res_rejected)
    else $error("rejection during window fill");

endmodule : ecgf_window

`default_nettype wire

// ----- tb/glitch_filter_checker.sv -----
// ----------------------------------------------------------------------------
// glitch_filter_checker - result predictor and comparator for the filter
// Watches the request, result and register ports of the encoder count glitch
// filter. It decodes every accepted request word, runs it against its own
// copy of the sample window and jump limit, and queues the expected count.
// Each accepted result is compared field by field with the oldest expected
// count. It reports the mismatch count, the number of counts still expected
// and the current window mean, which the stimulus uses to aim its samples.
// ----------------------------------------------------------------------------

module glitch_filter_checker
  import ecgf_pkg::*;
#(
  parameter int WINDOW = 10
)
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_wr_en,
  input  wire  [LIM_W-1:0] cfg_wr_data,
  input  wire              in_valid,
  input  wire              in_ready,
  input  wire  [RAW_W-1:0] in_raw_word,
  input  wire              out_valid,
  input  wire              out_ready,
  input  wire  [CNT_W-1:0] out_filtered_count,
  input  wire              out_was_rejected,
  output int               mismatches,
  output int               pending,
  output longint           window_mean
);

  typedef struct packed {
    count_t count;
    logic   rejected;
  } filtered_t;

  // Model state: stored samples, fill level, running sum and limit
  count_t    window_samples [WINDOW];
  int        stored;
  longint    window_sum;
  limit_t    jump_limit;
  filtered_t expected_counts [$];

  // Decode the magnitude, apply the sign offset, reverse direction
  function automatic count_t decode_count(input logic [RAW_W-1:0] raw);
    longint v;
    v = longint'(raw[MAG_W-1:0]);
    if (raw[SIGN_BIT]) begin
      v = v - longint'(SIGN_OFFSET);
    end
    return count_t'(-v);
  endfunction

  // Fill the window first, then reject outliers against the mean
  function automatic filtered_t filter_count(input logic [RAW_W-1:0] raw);
    count_t    count_in;
    longint    mean;
    longint    distance;
    filtered_t res;
    count_in     = decode_count(raw);
    res.count    = count_in;
    res.rejected = 1'b0;
    if (stored < WINDOW) begin
      window_samples[stored] = count_in;
      window_sum += count_in;
      stored++;
    end else begin
      mean     = window_sum / WINDOW;
      distance = longint'(count_in) - mean;
      if (distance < 0) begin
        distance = -distance;
      end
      if (distance > longint'(jump_limit)) begin
        // Hold the window, repeat the newest stored sample
        res.count    = window_samples[WINDOW-1];
        res.rejected = 1'b1;
      end else begin
        // Shift the window and take the new sample
        window_sum -= window_samples[0];
        for (int i = 0; i < WINDOW - 1; i++) begin
          window_samples[i] = window_samples[i+1];
        end
        window_samples[WINDOW-1] = count_in;
        window_sum += count_in;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    filtered_t got;
    filtered_t want;
    if (!rst_n) begin
      stored     = 0;
      window_sum = 0;
      jump_limit = LIMIT_RESET;
      expected_counts.delete();
    end else begin
      // Compare an accepted result with the oldest expected count
      if (out_valid && out_ready) begin
        got.count    = out_filtered_count;
        got.rejected = out_was_rejected;
        if (expected_counts.size() == 0) begin
          $display("%0t: result with none expected: count %0d rejected %0b",
                   $time, $signed(got.count), got.rejected);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (got.count !== want.count) begin
            $display("%0t: filtered_count expected %0d got %0d",
                     $time, $signed(want.count), $signed(got.count));
            mismatches++;
          end
          if (got.rejected !== want.rejected) begin
            $display("%0t: was_rejected expected %0b got %0b",
                     $time, want.rejected, got.rejected);
            mismatches++;
          end
        end
      end
      // Predict the count for an accepted request
      if (in_valid && in_ready) begin
        expected_counts.push_back(filter_count(in_raw_word));
      end
      if (cfg_wr_en) begin
        jump_limit = cfg_wr_data;
      end
    end
    pending     = expected_counts.size();
    window_mean = (stored == 0) ? 0 : window_sum / WINDOW;
  end

endmodule : glitch_filter_checker

// ----- tb/encoder_count_glitch_filter_top_tb.sv -----
// ----------------------------------------------------------------------------
// encoder_count_glitch_filter_top_tb - testbench of the encoder glitch filter
// Fills the window with field extremes and probes the limit boundary under
// the reset limit, then runs random phases over several jump limits, zero and
// full scale among them. Most samples sit near the window mean, the rest are
// boundary values and raw glitches. Both sides idle at random; one long
// result hold-off backs up the pipeline and one pause drains it.
// ----------------------------------------------------------------------------

module encoder_count_glitch_filter_top_tb;
  import ecgf_pkg::*;

  localparam int     WINDOW          = 10;
  localparam int     CLK_PERIOD      = 12;
  localparam int     RESET_CYCLES    = 8;
  localparam int     LONG_HOLD       = 48;
  localparam int     RANDOM_PHASES   = 6;
  localparam int     ITEMS_PER_PHASE = 125;
  localparam int     DRAIN_CYCLES    = 8;
  localparam longint COUNT_MIN       = -16777215;
  localparam longint COUNT_MAX       = 16777216;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [LIM_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic [RAW_W-1:0] in_raw_word = '0;
  logic             out_ready   = 1'b0;

  wire              in_ready;
  wire              out_valid;
  wire  [CNT_W-1:0] out_filtered_count;
  wire              out_was_rejected;

  int     mismatches;
  int     pending;
  longint window_mean;

  bit no_gaps       = 1'b0;
  bit sink_hold_req = 1'b0;
  int stall_left    = 0;

  encoder_count_glitch_filter_top #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_word       (in_raw_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered_count(out_filtered_count),
    .out_was_rejected  (out_was_rejected)
  );

  glitch_filter_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_word       (in_raw_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered_count(out_filtered_count),
    .out_was_rejected  (out_was_rejected),
    .mismatches        (mismatches),
    .pending           (pending),
    .window_mean       (window_mean)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Build a raw word that decodes to the target, with random ignored bits
  function automatic logic [RAW_W-1:0] encode_count(input longint target);
    logic [RAW_W-1:0] raw;
    raw = $urandom;
    if (target <= 0) begin
      raw[SIGN_BIT]  = 1'b0;
      raw[MAG_W-1:0] = MAG_W'(-target);
    end else begin
      raw[SIGN_BIT]  = 1'b1;
      raw[MAG_W-1:0] = MAG_W'(longint'(SIGN_OFFSET) - target);
    end
    return raw;
  endfunction

  // Aim most samples near the window mean so the window keeps moving
  function automatic logic [RAW_W-1:0] pick_word(input longint lim);
    longint span;
    longint target;
    longint offset;
    int     roll;
    roll = $urandom_range(0, 99);
    span = lim + lim / 8 + 2;
    if (roll < 15) begin
      return $urandom;
    end else if (roll < 27) begin
      offset = lim + $urandom_range(0, 1);
      target = window_mean + ($urandom_range(0, 1) ? offset : -offset);
    end else begin
      target = window_mean + longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    if (target < COUNT_MIN) target = COUNT_MIN;
    if (target > COUNT_MAX) target = COUNT_MAX;
    return encode_count(target);
  endfunction

  // Offer one request and hold it until taken, then maybe idle
  task automatic send_word(input logic [RAW_W-1:0] raw);
    int gap;
    in_valid    <= 1'b1;
    in_raw_word <= raw;
    do @(posedge clk); while (!in_ready);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected count has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input limit_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result side: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      stall_left    = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #(CLK_PERIOD * 700_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    limit_t lim;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the window with field extremes; the sum comes to zero
    send_word(32'h0000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0001);
    send_word(32'h8000_0000);
    send_word(32'h00FF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0002);
    send_word(32'h7F00_0000);
    send_word(32'h5500_0000);
    send_word(32'h2A00_0000);
    // Reset limit: land exactly on it above, one past it on either side, then exactly on it below
    send_word(32'h80FF_F060);
    send_word(32'h80FF_EECF);
    send_word(32'h0000_0E11);
    send_word(32'h0000_0E10);
    // Far glitches in both directions
    send_word(32'h00FF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h0000_0000);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       lim = '0;
        1:       lim = '1;
        2:       lim = limit_t'($urandom_range(0, 255));
        3:       lim = LIMIT_RESET;
        4:       lim = limit_t'($urandom);
        default: lim = limit_t'($urandom_range(1000, 100000));
      endcase
      write_limit(lim);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        no_gaps = (k >= 30 && k < 60) || (phase == 1 && k >= 80 && k < 120);
        // Back up the pipeline while requests keep coming
        if (phase == 1 && k == 80) sink_hold_req = 1'b1;
        if (phase == 3 && k == 60) wait_drained();
        send_word(pick_word(longint'(lim)));
      end
      no_gaps = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : encoder_count_glitch_filter_top_tb

// ----- files.f -----
rtl/core/ecgf_pkg.sv
rtl/core/ecgf_cell.sv
rtl/core/ecgf_prep.sv
rtl/core/ecgf_window.sv
rtl/core/encoder_count_glitch_filter_top.sv
tb/glitch_filter_checker.sv
tb/encoder_count_glitch_filter_top_tb.sv
